@@ hw/rtl/mvm_pkg.sv @@
// Shared constants for the matrix-vector multiply block: field widths,
// item function codes and register selects. No dependencies.
`timescale 1ns / 1ps

package mvm_pkg;

	localparam int FUNC_W  = 2;
	localparam int IDX_W   = 4;
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 40;
	localparam int CNT_W   = 5;

	localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;
	localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;

	// item function codes (code 3 is ignored)
	localparam logic [FUNC_W-1:0] FUNC_WR_MATRIX = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WR_VECTOR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE   = 2'd2;

	// register select, paddr bit 2
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

endpackage

@@ hw/rtl/matrix_vector_multiply_top.sv @@
// Matrix-vector multiply: element stores, one shared multiply-accumulate
// unit under a row/column sequencer, APB register port. Uses mvm_pkg.
// A compute item is worked by the single MAC pipeline (read, multiply,
// accumulate) visiting each element in turn, one row after another; new
// items are not taken until it is done. A held output register extends a
// row only while the sink stalls.
// Reset (arst_n, async, low) clears control and sets both counts to 16;
// element stores are not cleared and must be written before use.
`timescale 1ns / 1ps

module matrix_vector_multiply_top
	import mvm_pkg::*;
#(
	parameter int MAX_ROWS   = 16,
	parameter int MAX_COLS   = 16,
	parameter int ELEM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // row_index[3:0], col_index[7:4], value[23:8]
	input  logic [1:0]  s_tuser,  // func[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // row_number[3:0], row_sum[43:4], zero[47:44]
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AWX   = AW + 1;
	localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int PW    = 2 * ELEM_WIDTH;

	localparam logic [CNT_W-1:0] ROW_CAP = (MAX_ROWS > 31) ? CNT_MAX : CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] COL_CAP = (MAX_COLS > 31) ? CNT_MAX : CNT_W'(MAX_COLS);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	// ---------------- configuration ----------------
	logic [CNT_W-1:0] row_count_q, col_count_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= CNT_RESET;
			col_count_q <= CNT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROW_COUNT: row_count_q <= pwdata[CNT_W-1:0];
				REG_COL_COUNT: col_count_q <= pwdata[CNT_W-1:0];
				default:       row_count_q <= row_count_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_ROW_COUNT: prdata[CNT_W-1:0] = row_count_q;
			REG_COL_COUNT: prdata[CNT_W-1:0] = col_count_q;
			default:       prdata = '0;
		endcase
	end

	logic [CNT_W-1:0] rows_eff, cols_eff;
	assign rows_eff = (row_count_q > ROW_CAP) ? ROW_CAP : row_count_q;
	assign cols_eff = (col_count_q > COL_CAP) ? COL_CAP : col_count_q;

	// ---------------- input decode ----------------
	logic [FUNC_W-1:0]         in_func;
	logic [IDX_W-1:0]          in_row, in_col;
	logic signed [VALUE_W-1:0] in_value;
	logic                      in_acc;
	logic [AWX-1:0]            wr_addr;
	logic                      wr_mat, wr_vec, start;

	assign in_func  = s_tuser;
	assign in_row   = s_tdata[3:0];
	assign in_col   = s_tdata[7:4];
	assign in_value = s_tdata[23:8];
	assign in_acc   = s_tvalid & s_tready;

	assign wr_addr = AWX'(in_row) * AWX'(MAX_COLS) + AWX'(in_col);
	assign wr_mat  = in_acc && (in_func == FUNC_WR_MATRIX)
		&& (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
	assign wr_vec  = in_acc && (in_func == FUNC_WR_VECTOR) && (int'(in_col) < MAX_COLS);
	assign start   = in_acc && (in_func == FUNC_COMPUTE);

	// ---------------- sequencer ----------------
	state_t           state_q;
	logic [CNT_W-1:0] row_q, col_q;
	logic [AWX-1:0]   base_q;
	logic             rd_vld_s1, mul_vld_s2;
	logic             out_valid_q, out_last_q;
	logic             issue, pipe_empty, out_load;

	assign s_tready   = (state_q == ST_IDLE);
	assign issue      = (state_q == ST_RUN) && (col_q != cols_eff);
	assign pipe_empty = !rd_vld_s1 && !mul_vld_s2;
	assign out_load   = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			rd_vld_s1   <= 1'b0;
			mul_vld_s2  <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			mul_vld_s2 <= rd_vld_s1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					row_q  <= '0;
					col_q  <= '0;
					base_q <= '0;
					if (start && rows_eff != '0)
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (issue)
						col_q <= col_q + 1'b1;
					else
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (out_load) begin
						out_last_q  <= (row_q == rows_eff - 1'b1);
						col_q       <= '0;
						row_q       <= row_q + 1'b1;
						base_q      <= base_q + AWX'(MAX_COLS);
						state_q     <= (row_q == rows_eff - 1'b1) ? ST_IDLE : ST_RUN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- stores and MAC datapath ----------------
	logic signed [ELEM_WIDTH-1:0] mat_mem [DEPTH];
	logic signed [ELEM_WIDTH-1:0] vec_mem [MAX_COLS];
	logic signed [ELEM_WIDTH-1:0] mat_rd_s1, vec_rd_s1;
	logic signed [PW-1:0]         prod_s2;
	logic signed [SUM_W-1:0]      acc_q, out_sum_q;
	logic [IDX_W-1:0]             out_row_q;
	logic [AWX-1:0]               rd_addr;

	assign rd_addr = base_q + AWX'(col_q);

	always_ff @(posedge clk) begin
		if (wr_mat)
			mat_mem[wr_addr[AW-1:0]] <= ELEM_WIDTH'(in_value);
		if (wr_vec)
			vec_mem[CIW'(in_col)] <= ELEM_WIDTH'(in_value);
		if (issue) begin
			mat_rd_s1 <= mat_mem[rd_addr[AW-1:0]];
			vec_rd_s1 <= vec_mem[CIW'(col_q)];
		end
		prod_s2 <= mat_rd_s1 * vec_rd_s1;
		// accumulator restarts at the beginning of each row
		if (state_q == ST_IDLE || out_load)
			acc_q <= '0;
		else if (mul_vld_s2)
			acc_q <= acc_q + SUM_W'(prod_s2);
		if (out_load) begin
			out_sum_q <= acc_q;
			out_row_q <= row_q[IDX_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0, out_sum_q, out_row_q};

	// ---------------- assertions ----------------
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!rd_vld_s1 && !mul_vld_s2))
		else $error("MAC pipeline busy while taking items");

	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DRAIN))
		else $error("result appeared outside drain");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !out_load)
		else $error("pending result overwritten");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (row_q < rows_eff))
		else $error("row counter past configured rows");

endmodule
